// File: hdl/egvp_pkg.sv
// ----------------------------------------------------------------------------
// egvp_pkg
// Shared widths, constants and the queue item type of the order-1
// exponential Golomb packer.
// ----------------------------------------------------------------------------
package egvp_pkg;

  localparam int VALUE_W = 32;              // count_value width
  localparam int WORD_W  = 32;              // packed word width
  localparam int CNT_W   = 18;              // total bit count width
  localparam int SUM_W   = VALUE_W + 1;     // width of value + 2
  localparam int CODE_W  = 2 * VALUE_W;     // longest code
  localparam int LEN_W   = $clog2(CODE_W + 1);
  localparam int FREE_W  = $clog2(WORD_W + 1);
  localparam int NPOS_W  = $clog2(SUM_W);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // One classified item: the code left aligned in CODE_W bits and its length.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } egvp_item_t;

endpackage

// File: hdl/egvp_front.sv
// ----------------------------------------------------------------------------
// egvp_front
// Input register and classifier: finds the code length and left aligns
// the code before handing the item to the queue.
// ----------------------------------------------------------------------------
module egvp_front
  import egvp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_count_value,
  input  logic               in_last_place,
  output logic               push,
  input  logic               full,
  output egvp_item_t         push_item
);

  logic             a_valid_r, a_valid_nxt;
  logic [SUM_W-1:0] a_sum_r;
  logic             a_last_r;
  logic [NPOS_W-1:0] lead_pos;
  logic [LEN_W-1:0]  code_len;
  logic [LEN_W-1:0]  align_sh;
  logic              accept;

  assign push     = a_valid_r && !full;
  assign in_ready = !a_valid_r || !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  // The code of v is v + 2 written in 2n bits, n being the position of the
  // leading one of v + 2.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_sum_r  <= {1'b0, in_count_value} + SUM_W'(2);
      a_last_r <= in_last_place;
    end
  end

  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (a_sum_r[i]) begin
        lead_pos = NPOS_W'(i);
      end
    end
  end

  assign code_len = {lead_pos, 1'b0};
  assign align_sh = LEN_W'(CODE_W) - code_len;

  assign push_item.code = {{(CODE_W-SUM_W){1'b0}}, a_sum_r} << align_sh;
  assign push_item.len  = code_len;
  assign push_item.last = a_last_r;

endmodule

// File: hdl/egvp_queue.sv
// ----------------------------------------------------------------------------
// egvp_queue
// Two-entry queue between the classifier and the packing engine.
// ----------------------------------------------------------------------------
module egvp_queue
  import egvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  egvp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       q_valid,
  output egvp_item_t q_item
);

  egvp_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full    = (fill_r == 2'd2);
  assign q_valid = (fill_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// File: hdl/egvp_back.sv
// ----------------------------------------------------------------------------
// egvp_back
// Packing engine: moves code bits into the partial word one chunk per
// cycle while the output is free, emits full words, flushes on the last item.
// ----------------------------------------------------------------------------
module egvp_back
  import egvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  egvp_item_t        q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_packed_word,
  output logic              out_final_word,
  output logic [CNT_W-1:0]  out_total_bits
);

  logic              have_r, have_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              last_r, last_nxt;
  logic [WORD_W-1:0] part_r, part_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  logic [WORD_W-1:0] ow_r, ow_nxt;
  logic              of_r, of_nxt;
  logic [CNT_W-1:0]  ot_r, ot_nxt;

  logic              out_free;
  logic              step;
  logic              emit;
  logic [LEN_W-1:0]  take;
  logic [WORD_W-1:0] part_fill;
  logic [FREE_W-1:0] free_left;
  logic [LEN_W-1:0]  rem_left;
  logic [CNT_W:0]    cnt_sum;

  assign out_free = !ov_r || out_ready;
  assign pop      = !have_r && q_valid;
  assign step     = have_r && out_free;

  assign take      = (rem_r < LEN_W'(free_r)) ? rem_r : LEN_W'(free_r);
  // The code is left aligned, so the top bits drop straight into the free
  // low positions of the partial word; bits past the code are zero.
  assign part_fill = part_r |
                     (code_r[CODE_W-1 -: WORD_W] >> (FREE_W'(WORD_W) - free_r));
  assign free_left = free_r - FREE_W'(take);
  assign rem_left  = rem_r - take;
  assign cnt_sum   = {1'b0, cnt_r} + (CNT_W+1)'(q_item.len);

  always_comb begin
    have_nxt = have_r;
    code_nxt = code_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    part_nxt = part_r;
    free_nxt = free_r;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    ow_nxt   = ow_r;
    of_nxt   = of_r;
    ot_nxt   = ot_r;
    if (pop) begin
      have_nxt = 1'b1;
      code_nxt = q_item.code;
      rem_nxt  = q_item.len;
      last_nxt = q_item.last;
      cnt_nxt  = cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
    end else if (step) begin
      if (rem_r != '0) begin
        code_nxt = code_r << take;
        rem_nxt  = rem_left;
        part_nxt = part_fill;
        free_nxt = free_left;
        if (free_left == '0) begin
          emit     = 1'b1;
          ow_nxt   = part_fill;
          of_nxt   = last_r && (rem_left == '0);
          ot_nxt   = (last_r && (rem_left == '0)) ? cnt_r : '0;
          part_nxt = '0;
          free_nxt = FREE_W'(WORD_W);
        end
        if (rem_left == '0) begin
          if (!last_r) begin
            have_nxt = 1'b0;
          end else if (free_left == '0) begin
            // Last code filled its word exactly: no padding word follows.
            have_nxt = 1'b0;
            cnt_nxt  = '0;
          end
        end
      end else begin
        // Flush the partly filled word of the last item.
        emit     = 1'b1;
        ow_nxt   = part_r;
        of_nxt   = 1'b1;
        ot_nxt   = cnt_r;
        part_nxt = '0;
        free_nxt = FREE_W'(WORD_W);
        cnt_nxt  = '0;
        have_nxt = 1'b0;
      end
    end
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      part_r <= '0;
      free_r <= FREE_W'(WORD_W);
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      have_r <= have_nxt;
      part_r <= part_nxt;
      free_r <= free_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    rem_r  <= rem_nxt;
    last_r <= last_nxt;
    ow_r   <= ow_nxt;
    of_r   <= of_nxt;
    ot_r   <= ot_nxt;
  end

  assign out_valid       = ov_r;
  assign out_packed_word = ow_r;
  assign out_final_word  = of_r;
  assign out_total_bits  = ot_r;

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r != '0) && (free_r <= FREE_W'(WORD_W)))
    else $error("free bit count out of range");

  a_flush_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    have_r && (rem_r == '0) |-> last_r)
    else $error("flush phase on an item that is not last");

  a_total_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !of_r |-> (ot_r == '0))
    else $error("bit total on a word that is not final");

  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    emit && of_nxt |=> (cnt_r == '0) && (free_r == FREE_W'(WORD_W)) && !have_r)
    else $error("packer not cleared after final word");

endmodule

// File: hdl/exp_golomb_value_packer.sv
// ----------------------------------------------------------------------------
// exp_golomb_value_packer
// Order-1 exponential Golomb encoder that packs codes MSB first into words.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  input     in_valid/in_ready, in_count_value,      in
//            in_last_place
//  result    out_valid/out_ready, out_packed_word,   out
//            out_final_word, out_total_bits
//
// The classifier takes one item per cycle, while the queue is not full, into a
// two-entry queue. The packing engine loads an item only once the last one is
// done, moves one word fragment of its code (one to three) per cycle while the
// output is free, and for a last item flushes the padded word. A count reaches
// out_valid through the input register, the queue, the engine's item registers
// and the output word register. Synchronous reset empties the queue and the
// partial word; a stalled result holds the engine, the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module exp_golomb_value_packer
  import egvp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_count_value,
  input  logic               in_last_place,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  out_packed_word,
  output logic               out_final_word,
  output logic [CNT_W-1:0]   out_total_bits
);

  logic       push;
  logic       full;
  logic       pop;
  logic       q_valid;
  egvp_item_t push_item;
  egvp_item_t q_item;

  egvp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_count_value (in_count_value),
    .in_last_place  (in_last_place),
    .push           (push),
    .full           (full),
    .push_item      (push_item)
  );

  egvp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  egvp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_final_word  (out_final_word),
    .out_total_bits  (out_total_bits)
  );

endmodule

// File: test/tb_exp_golomb_value_packer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_exp_golomb_value_packer
// Self-checking bench for the order-1 exponential Golomb word packer. Counts
// are sent in vectors that end with last_place. A bit-serial packer in the
// bench predicts the words of all but the typed table rows, which carry their
// own; all are compared with the block's output. Two parts are run: a table
// of edge cases and random vectors of mixed code lengths.
// ----------------------------------------------------------------------------
module tb_exp_golomb_value_packer;
  import egvp_pkg::*;

  localparam int RANDOM_ITEMS = 330;
  localparam int IDLE_PCT     = 12;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              fin;
    logic [CNT_W-1:0]  total;
  } word_result_t;

  // A stimulus row. Where typed is set, the expected words are given in the
  // row (at most two), and the predictor is only kept in step.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               typed;
    logic [1:0]         n_exp;
    logic [WORD_W-1:0]  w0;
    logic               f0;
    logic [CNT_W-1:0]   t0;
    logic [WORD_W-1:0]  w1;
    logic               f1;
    logic [CNT_W-1:0]   t1;
  } count_row_t;

  localparam int DIR_N = 20;
  localparam count_row_t DIR_ROWS [DIR_N] = '{
    // Smallest count alone: code "10".
    '{32'h00000000, 1'b1, 1'b1, 2'd1, 32'h80000000, 1'b1, 18'd2,
      32'h0, 1'b0, 18'd0},
    // Largest count: 64-bit code that ends exactly on a word boundary.
    '{32'hFFFFFFFF, 1'b1, 1'b1, 2'd2, 32'h00000001, 1'b0, 18'd0,
      32'h00000001, 1'b1, 18'd64},
    '{32'hFFFFFFFE, 1'b1, 1'b1, 2'd2, 32'h00000001, 1'b0, 18'd0,
      32'h00000000, 1'b1, 18'd64},
    '{32'h00000001, 1'b1, 1'b1, 2'd1, 32'hC0000000, 1'b1, 18'd2,
      32'h0, 1'b0, 18'd0},
    '{32'h00000002, 1'b1, 1'b1, 2'd1, 32'h40000000, 1'b1, 18'd4,
      32'h0, 1'b0, 18'd0},
    // Four 8-bit codes fill one word exactly on the last item.
    '{32'd14, 1'b0, 1'b1, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'd14, 1'b0, 1'b1, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'd14, 1'b0, 1'b1, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'd14, 1'b1, 1'b1, 2'd1, 32'h10101010, 1'b1, 18'd32,
      32'h0, 1'b0, 18'd0},
    // A longest code after a short one yields two full words and a flush.
    '{32'h00000000, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'hFFFFFFFF, 1'b1, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'h7FFFFFFF, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'h80000000, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'h12345678, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'hFFFFFFFD, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'h55555555, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'hAAAAAAAA, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'd3, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'd5, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0},
    '{32'd6, 1'b1, 1'b0, 2'd0, 32'h0, 1'b0, 18'd0, 32'h0, 1'b0, 18'd0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_count_value = '0;
  logic               in_last_place = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WORD_W-1:0]  out_packed_word;
  logic               out_final_word;
  logic [CNT_W-1:0]   out_total_bits;

  // Predictor state: the word being filled, its free positions, and the
  // running bit length of the current vector.
  logic [WORD_W-1:0]  pend_word = '0;
  int                 pend_free = WORD_W;
  logic [CNT_W-1:0]   vec_bits = '0;

  word_result_t       expected_words [$];
  word_result_t       step_words [$];
  word_result_t       head;
  bit                 calm = 1'b0;
  int                 errors = 0;
  int                 counts_sent = 0;
  int                 words_checked = 0;
  int                 vectors_sent = 0;

  exp_golomb_value_packer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_count_value  (in_count_value),
    .in_last_place   (in_last_place),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_final_word  (out_final_word),
    .out_total_bits  (out_total_bits)
  );

  always #10 clk = ~clk;

  // Encodes one count and shifts its code into the pending word one bit at a time;
  // every completed word, and the flushed word of a last count, goes to step_words.
  task automatic encode_count(input logic [VALUE_W-1:0] v, input logic last);
    logic [63:0]    rem;
    logic [63:0]    span;
    logic [63:0]    code;
    logic [CNT_W:0] sum;
    logic           fin;
    int             n;
    int             len;
    step_words.delete();
    rem = 64'(v);
    span = 64'd2;
    n = 1;
    while (rem >= span) begin
      rem -= span;
      span <<= 1;
      n++;
    end
    code = (64'd1 << n) | rem;
    len = 2 * n;
    sum = {1'b0, vec_bits} + (CNT_W + 1)'(len);
    vec_bits = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
    for (int i = len - 1; i >= 0; i--) begin
      pend_word[pend_free-1] = code[i];
      pend_free--;
      if (pend_free == 0) begin
        fin = last && (i == 0);
        step_words.push_back('{pend_word, fin, fin ? vec_bits : '0});
        pend_word = '0;
        pend_free = WORD_W;
      end
    end
    if (last) begin
      if (pend_free < WORD_W) step_words.push_back('{pend_word, 1'b1, vec_bits});
      pend_word = '0;
      pend_free = WORD_W;
      vec_bits = '0;
    end
  endtask

  // Offers one count and returns at the edge of its transfer, with the
  // predicted words already in step_words.
  task automatic send_count(input logic [VALUE_W-1:0] v, input logic last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_count_value <= v;
    in_last_place <= last;
    do @(posedge clk); while (!in_ready);
    encode_count(v, last);
    counts_sent++;
    if (last) vectors_sent++;
  endtask

  // Picks a code length first so that short and long codes are equally
  // likely, then a count within that length; now and then a raw word.
  function automatic logic [VALUE_W-1:0] pick_count();
    logic [63:0] lo;
    logic [63:0] hi;
    int          n;
    if ($urandom_range(0, 9) == 0) return $urandom();
    n = $urandom_range(1, 32);
    lo = (64'd1 << n) - 64'd2;
    hi = (64'd1 << (n + 1)) - 64'd3;
    if (hi > 64'hFFFFFFFF) hi = 64'hFFFFFFFF;
    return VALUE_W'(lo + 64'($urandom()) % (hi - lo + 64'd1));
  endfunction

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("word %h arrived with nothing expected", out_packed_word);
        errors++;
      end else begin
        head = expected_words.pop_front();
        if (out_packed_word !== head.word) begin
          $error("packed_word: expected %h, got %h", head.word, out_packed_word);
          errors++;
        end
        if (out_final_word !== head.fin) begin
          $error("final_word: expected %0d, got %0d", head.fin, out_final_word);
          errors++;
        end
        if (out_total_bits !== head.total) begin
          $error("total_bits: expected %0d, got %0d", head.total, out_total_bits);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int vec_len;
    int guard;
    bit last;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[r]) begin
      send_count(DIR_ROWS[r].value, DIR_ROWS[r].last);
      if (DIR_ROWS[r].typed) begin
        if (DIR_ROWS[r].n_exp >= 2'd1)
          expected_words.push_back('{DIR_ROWS[r].w0, DIR_ROWS[r].f0, DIR_ROWS[r].t0});
        if (DIR_ROWS[r].n_exp >= 2'd2)
          expected_words.push_back('{DIR_ROWS[r].w1, DIR_ROWS[r].f1, DIR_ROWS[r].t1});
      end else begin
        foreach (step_words[k]) expected_words.push_back(step_words[k]);
      end
    end

    // Random vectors; the middle stretch runs without any idling on either side.
    while (counts_sent < DIR_N + RANDOM_ITEMS) begin
      vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                            : $urandom_range(1, 12);
      for (int i = 0; i < vec_len; i++) begin
        calm = (counts_sent >= DIR_N + 150) && (counts_sent < DIR_N + 240);
        last = (i == vec_len - 1) || (counts_sent + 1 >= DIR_N + RANDOM_ITEMS);
        send_count(pick_count(), last);
        foreach (step_words[k]) expected_words.push_back(step_words[k]);
        if (last) break;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    guard = 0;
    while (expected_words.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      errors++;
    end

    $display("Sent %0d counts in %0d vectors, checked %0d packed words,",
             counts_sent, vectors_sent, words_checked);
    $display("including exact word fills, three-word items and stalls on both sides.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/egvp_pkg.sv
hdl/egvp_front.sv
hdl/egvp_queue.sv
hdl/egvp_back.sv
hdl/exp_golomb_value_packer.sv
test/tb_exp_golomb_value_packer.sv
